// File: hdl/sbc_pkg.sv
// Shared constants, types and register codes for the step band classifier.
package sbc_pkg;

  localparam int MAX_STEPS = 6;
  localparam int NUM_COMPS = 4;
  localparam int COMP_W    = 16;
  localparam int THR_W     = 36;
  localparam int SQ_W      = 31;  // (-32768)^2 = 2^30 fits unsigned in 31 bits
  localparam int SUM_W     = 33;  // four squares, at most 2^32
  localparam int Q_W       = 37;  // measured quantity, wide enough for thresholds
  localparam int KIND_W    = 3;
  localparam int STEP_W    = 3;
  localparam int BAND_W    = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VALUE_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_D = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_E = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_F = 3'd7;

  localparam logic [KIND_W-1:0] KIND_SCALAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VEC2   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_VEC3   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VEC4   = 3'd3;

  localparam logic signed [BAND_W-1:0] BAND_NONE = -4'sd1;

  typedef logic signed [THR_W-1:0] thresh_t;

  // Per-lane compare results against each threshold.
  typedef struct packed {
    logic [MAX_STEPS-1:0] below;  // q <  t[i]
    logic [MAX_STEPS-1:0] above;  // q >  t[i]
  } cmp_flags_t;

endpackage

// File: hdl/sbc_square.sv
// Squarer lane: registered square of one signed component.
module sbc_square (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [sbc_pkg::COMP_W-1:0] comp,
  output logic        [sbc_pkg::SQ_W-1:0]   sq
);

  logic signed [2*sbc_pkg::COMP_W-1:0] prod;

  assign prod = comp * comp;

  always_ff @(posedge clk) begin
    if (load) begin
      sq <= prod[sbc_pkg::SQ_W-1:0];
    end
  end

endmodule

// File: hdl/sbc_cmp_lane.sv
// Comparator lane: places the quantity against one threshold.
module sbc_cmp_lane (
  input  logic signed [sbc_pkg::Q_W-1:0] q,
  input  sbc_pkg::thresh_t               thr,
  output logic                           below,
  output logic                           above
);

  logic signed [sbc_pkg::Q_W-1:0] thr_ext;

  assign thr_ext = sbc_pkg::Q_W'(thr);
  assign below   = q < thr_ext;
  assign above   = q > thr_ext;

endmodule

// File: hdl/sbc_merge.sv
// Merge stage: turns the lane compare flags into a band index.
module sbc_merge (
  input  sbc_pkg::cmp_flags_t                flags,
  input  logic                               asc,
  input  logic        [sbc_pkg::STEP_W-1:0]  n,
  input  logic signed [sbc_pkg::BAND_W-1:0]  cur,
  output logic signed [sbc_pkg::BAND_W-1:0]  band_next
);

  always_comb begin
    logic [sbc_pkg::STEP_W-1:0] last;
    logic                       hit;
    last = n - 3'd1;
    band_next = cur;
    if (asc) begin
      if (flags.below[0]) begin
        band_next = sbc_pkg::BAND_NONE;
      end else if (!flags.below[last]) begin
        band_next = {1'b0, last};
      end
    end else begin
      if (flags.above[0]) begin
        band_next = sbc_pkg::BAND_NONE;
      end else if (!flags.above[last]) begin
        band_next = {1'b0, last};
      end
    end
    // interior bands win over the end tests; lowest index has priority
    for (int i = sbc_pkg::MAX_STEPS - 2; i >= 0; i--) begin
      hit = asc ? (!flags.below[i] && flags.below[i+1])
                : (!flags.above[i] && flags.above[i+1]);
      if (hit && (i < int'(n) - 1)) begin
        band_next = sbc_pkg::BAND_W'(i);
      end
    end
  end

endmodule

// File: hdl/step_band_classifier.sv
// Step band classifier top level: squarer lanes, comparator lanes and merge.
//
// Input channel (in_valid/in_ready) carries one sample beat of four signed
// 16-bit components. Output channel (out_valid/out_ready) returns one beat
// per sample: the band index and a flag that is set when it moved.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
// written while no sample is in flight.
// The input beat passes through the registered squarer lanes, then through
// the comparator lanes and merge into the output register.
// Throughput: one sample per cycle while out_ready holds; a new beat is taken
// in the same cycle the previous one moves into the output register.
// When the receiver stalls, the result waits in the output register and the
// sample behind it waits in the squarer stage; in_ready drops after that.
// Reset clears all valids, sets value_kind to scalar, step_count to one,
// all thresholds to zero and the stored band to minus one.
module step_band_classifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic        [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [sbc_pkg::THR_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sbc_pkg::COMP_W-1:0]   comp_x,
  input  logic signed [sbc_pkg::COMP_W-1:0]   comp_y,
  input  logic signed [sbc_pkg::COMP_W-1:0]   comp_z,
  input  logic signed [sbc_pkg::COMP_W-1:0]   comp_w,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                changed,
  output logic signed [sbc_pkg::BAND_W-1:0]   band_index
);

  logic [sbc_pkg::KIND_W-1:0] value_kind;
  logic [sbc_pkg::STEP_W-1:0] step_count;
  sbc_pkg::thresh_t           thr [sbc_pkg::MAX_STEPS];

  logic                               busy;
  logic                               accept;
  logic                               finish;
  logic signed [sbc_pkg::BAND_W-1:0]  current_band;

  logic [sbc_pkg::STEP_W-1:0]         n_eff;
  logic                               asc_in;
  logic signed [sbc_pkg::COMP_W-1:0]  s1_x;
  logic                               s1_vec;
  logic                               s1_use_z;
  logic                               s1_use_w;
  logic                               s1_active;
  logic                               s1_asc;
  logic [sbc_pkg::STEP_W-1:0]         s1_n;

  logic signed [sbc_pkg::COMP_W-1:0]  comps [sbc_pkg::NUM_COMPS];
  logic [sbc_pkg::SQ_W-1:0]           sq    [sbc_pkg::NUM_COMPS];
  logic [sbc_pkg::SUM_W-1:0]          sum;
  logic signed [sbc_pkg::Q_W-1:0]     q;
  sbc_pkg::cmp_flags_t                flags;
  logic signed [sbc_pkg::BAND_W-1:0]  band_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      value_kind <= sbc_pkg::KIND_SCALAR;
      step_count <= 3'd1;
      for (int i = 0; i < sbc_pkg::MAX_STEPS; i++) begin
        thr[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        sbc_pkg::REG_VALUE_KIND:  value_kind <= cfg_data[sbc_pkg::KIND_W-1:0];
        sbc_pkg::REG_STEP_COUNT:  step_count <= cfg_data[sbc_pkg::STEP_W-1:0];
        sbc_pkg::REG_THRESHOLD_A: thr[0] <= cfg_data;
        sbc_pkg::REG_THRESHOLD_B: thr[1] <= cfg_data;
        sbc_pkg::REG_THRESHOLD_C: thr[2] <= cfg_data;
        sbc_pkg::REG_THRESHOLD_D: thr[3] <= cfg_data;
        sbc_pkg::REG_THRESHOLD_E: thr[4] <= cfg_data;
        sbc_pkg::REG_THRESHOLD_F: thr[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero counts as one, above the list saturates
  always_comb begin
    if (step_count == '0) begin
      n_eff = 3'd1;
    end else if (step_count > sbc_pkg::STEP_W'(sbc_pkg::MAX_STEPS)) begin
      n_eff = sbc_pkg::STEP_W'(sbc_pkg::MAX_STEPS);
    end else begin
      n_eff = step_count;
    end
  end

  assign asc_in = thr[n_eff - 3'd1] > thr[0];

  assign finish   = busy && (!out_valid || out_ready);
  assign in_ready = !busy || finish;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  // stage 1: squarer lanes plus decoded controls
  assign comps[0] = comp_x;
  assign comps[1] = comp_y;
  assign comps[2] = comp_z;
  assign comps[3] = comp_w;

  for (genvar g = 0; g < sbc_pkg::NUM_COMPS; g++) begin : g_sq
    sbc_square u_sq (
      .clk  (clk),
      .load (accept),
      .comp (comps[g]),
      .sq   (sq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x      <= comp_x;
      s1_vec    <= value_kind != sbc_pkg::KIND_SCALAR;
      s1_use_z  <= value_kind == sbc_pkg::KIND_VEC3 || value_kind == sbc_pkg::KIND_VEC4;
      s1_use_w  <= value_kind == sbc_pkg::KIND_VEC4;
      s1_active <= value_kind <= sbc_pkg::KIND_VEC4;
      s1_asc    <= asc_in;
      s1_n      <= n_eff;
    end
  end

  // stage 2: quantity, comparator lanes, merge
  assign sum = sbc_pkg::SUM_W'(sq[0]) + sbc_pkg::SUM_W'(sq[1])
             + (s1_use_z ? sbc_pkg::SUM_W'(sq[2]) : '0)
             + (s1_use_w ? sbc_pkg::SUM_W'(sq[3]) : '0);

  assign q = s1_vec ? $signed(sbc_pkg::Q_W'(sum)) : sbc_pkg::Q_W'(s1_x);

  for (genvar g = 0; g < sbc_pkg::MAX_STEPS; g++) begin : g_cmp
    sbc_cmp_lane u_cmp (
      .q     (q),
      .thr   (thr[g]),
      .below (flags.below[g]),
      .above (flags.above[g])
    );
  end

  sbc_merge u_merge (
    .flags     (flags),
    .asc       (s1_asc),
    .n         (s1_n),
    .cur       (current_band),
    .band_next (band_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      current_band <= sbc_pkg::BAND_NONE;
    end else if (finish && s1_active) begin
      current_band <= band_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      changed    <= s1_active && (band_next != current_band);
      band_index <= s1_active ? band_next : current_band;
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    busy && !out_valid && !in_valid |=> !busy)
    else $error("busy did not clear with a free output register");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> band_index == current_band)
    else $error("presented band differs from stored band");

  a_inactive_no_change: assert property (@(posedge clk) disable iff (rst)
    finish && !s1_active |=> !changed)
    else $error("change flagged for a never-change kind");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> band_index <= 4'sd5)
    else $error("band index out of range");

endmodule

// File: sim/tb_step_band_classifier.sv
// Self-checking testbench for the step band classifier: directed table, random phases.
module tb_step_band_classifier;

  localparam logic [sbc_pkg::KIND_W-1:0] KIND_HOLD  = 3'd4;  // never reports a change
  localparam logic [sbc_pkg::KIND_W-1:0] KIND_UNDEF = 3'd7;
  localparam logic signed [sbc_pkg::COMP_W-1:0] CMIN = 16'sh8000;
  localparam logic signed [sbc_pkg::COMP_W-1:0] CMAX = 16'sh7fff;
  localparam longint THR_MIN = -64'sd34359738368;
  localparam longint THR_MAX = 64'sd34359738367;
  localparam longint P30 = 64'sd1073741824;
  localparam longint P31 = 64'sd2147483648;
  localparam longint P32 = 64'sd4294967296;
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 17;
  localparam int PHASE_BEATS = 50;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [sbc_pkg::KIND_W-1:0]                          kind;
    logic [sbc_pkg::STEP_W-1:0]                          steps;
    logic [sbc_pkg::MAX_STEPS-1:0][sbc_pkg::THR_W-1:0]   thr;
  } band_cfg_t;

  typedef struct packed {
    logic                              chg;
    logic signed [sbc_pkg::BAND_W-1:0] band;
  } band_beat_t;

  typedef struct packed {
    logic [3:0]                        preset;
    logic signed [sbc_pkg::COMP_W-1:0] x;
    logic signed [sbc_pkg::COMP_W-1:0] y;
    logic signed [sbc_pkg::COMP_W-1:0] z;
    logic signed [sbc_pkg::COMP_W-1:0] w;
    bit                                typed;
    logic                              chg;
    logic signed [sbc_pkg::BAND_W-1:0] band;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbc_pkg::THR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [sbc_pkg::COMP_W-1:0] comp_x = '0;
  logic signed [sbc_pkg::COMP_W-1:0] comp_y = '0;
  logic signed [sbc_pkg::COMP_W-1:0] comp_z = '0;
  logic signed [sbc_pkg::COMP_W-1:0] comp_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic changed;
  logic signed [sbc_pkg::BAND_W-1:0] band_index;

  // expectation typed into the table, travels with the input beat
  bit typed_valid = 1'b0;
  band_beat_t typed_beat = '0;

  // shadow of the block's registers and stored band
  logic [sbc_pkg::KIND_W-1:0] shadow_kind;
  logic [sbc_pkg::STEP_W-1:0] shadow_steps;
  logic signed [sbc_pkg::THR_W-1:0] shadow_thr [sbc_pkg::MAX_STEPS];
  logic signed [sbc_pkg::BAND_W-1:0] shadow_band;

  band_beat_t pending_bands [$];
  dir_row_t dir_rows [N_DIRECTED];

  int err_count = 0;
  int samples_in = 0;
  int results_out = 0;
  int settings_loaded = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_left = 0;
  bit rx_on = 1'b0;
  logic [7:0] kinds_seen = '0;
  logic [7:0] steps_seen = '0;

  step_band_classifier dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .comp_x     (comp_x),
    .comp_y     (comp_y),
    .comp_z     (comp_z),
    .comp_w     (comp_w),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .changed    (changed),
    .band_index (band_index)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void predict_band(input logic signed [sbc_pkg::COMP_W-1:0] x, y, z, w,
                                       output band_beat_t res);
    longint vx, vy, vz, vw, q, first_t, last_t;
    int n, idx, i;
    bit asc, hit;
    vx = x;
    vy = y;
    vz = z;
    vw = w;
    q = 0;
    res.chg = 1'b0;
    if (shadow_kind <= sbc_pkg::KIND_VEC4) begin
      n = int'(shadow_steps);
      if (n < 1) n = 1;
      if (n > sbc_pkg::MAX_STEPS) n = sbc_pkg::MAX_STEPS;
      case (shadow_kind)
        sbc_pkg::KIND_SCALAR: q = vx;
        sbc_pkg::KIND_VEC2:   q = vx * vx + vy * vy;
        sbc_pkg::KIND_VEC3:   q = vx * vx + vy * vy + vz * vz;
        default:              q = vx * vx + vy * vy + vz * vz + vw * vw;
      endcase
      first_t = shadow_thr[0];
      last_t = shadow_thr[n-1];
      asc = last_t > first_t;  // single threshold counts as descending
      idx = shadow_band;
      if (asc) begin
        if (q < first_t) idx = -1;
        else if (q >= last_t) idx = n - 1;
      end else begin
        if (q > first_t) idx = -1;
        else if (q <= last_t) idx = n - 1;
      end
      // first in-list band wins over the end tests
      hit = 1'b0;
      for (i = 0; i < n - 1; i++) begin
        if (!hit && (asc ? (q >= shadow_thr[i] && q < shadow_thr[i+1])
                         : (q > shadow_thr[i+1] && q <= shadow_thr[i]))) begin
          idx = i;
          hit = 1'b1;
        end
      end
      if (idx != shadow_band) begin
        res.chg = 1'b1;
        shadow_band = sbc_pkg::BAND_W'(idx);
      end
    end
    res.band = shadow_band;
  endfunction

  // result check, input prediction and register shadowing, all on sampled values
  always @(posedge clk) begin
    band_beat_t want, got;
    if (rst) begin
      shadow_kind = sbc_pkg::KIND_SCALAR;
      shadow_steps = 3'd1;
      for (int i = 0; i < sbc_pkg::MAX_STEPS; i++) shadow_thr[i] = '0;
      shadow_band = sbc_pkg::BAND_NONE;
    end else begin
      if (out_valid && out_ready) begin
        results_out++;
        if (pending_bands.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing pending: changed=%0b band=%0d",
                                  changed, band_index));
        end else begin
          want = pending_bands.pop_front();
          if (changed !== want.chg)
            flag_mismatch($sformatf("changed: got %0b expected %0b", changed, want.chg));
          if (band_index !== want.band)
            flag_mismatch($sformatf("band_index: got %0d expected %0d", band_index,
                                    want.band));
        end
      end
      if (in_valid && in_ready) begin
        samples_in++;
        predict_band(comp_x, comp_y, comp_z, comp_w, got);
        pending_bands.push_back(typed_valid ? typed_beat : got);
      end
      if (cfg_write) begin
        case (cfg_index)
          sbc_pkg::REG_VALUE_KIND: shadow_kind = cfg_data[sbc_pkg::KIND_W-1:0];
          sbc_pkg::REG_STEP_COUNT: shadow_steps = cfg_data[sbc_pkg::STEP_W-1:0];
          default: shadow_thr[cfg_index - sbc_pkg::REG_THRESHOLD_A] = cfg_data;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles, %0d results pending",
               idle_cycles, pending_bands.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: runs of ready and stall, with occasional long stall-free stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 7))
        0:       begin rx_on = 1'b1; rx_left = $urandom_range(30, 80); end
        1, 2, 3: begin rx_on = 1'b1; rx_left = $urandom_range(1, 6); end
        default: begin rx_on = 1'b0; rx_left = $urandom_range(1, 5); end
      endcase
    end
    rx_left--;
    out_ready <= rx_on;
  end

  function automatic band_cfg_t mk_cfg(input logic [sbc_pkg::KIND_W-1:0] kind, input int steps,
                                       input longint a, b, c, d, e, f);
    band_cfg_t r;
    r.kind = kind;
    r.steps = sbc_pkg::STEP_W'(steps);
    r.thr[0] = a[sbc_pkg::THR_W-1:0];
    r.thr[1] = b[sbc_pkg::THR_W-1:0];
    r.thr[2] = c[sbc_pkg::THR_W-1:0];
    r.thr[3] = d[sbc_pkg::THR_W-1:0];
    r.thr[4] = e[sbc_pkg::THR_W-1:0];
    r.thr[5] = f[sbc_pkg::THR_W-1:0];
    return r;
  endfunction

  function automatic band_cfg_t preset_cfg(input int p);
    case (p)
      1:       return mk_cfg(sbc_pkg::KIND_SCALAR, 6, THR_MIN, -30000, -1, 0, 32767, THR_MAX);
      2:       return mk_cfg(sbc_pkg::KIND_VEC4, 6, 0, 1, P30, P31, P32 - 1, P32);
      3:       return mk_cfg(sbc_pkg::KIND_VEC2, 4, P31, P30, 1000, 0, 0, 0);
      4:       return mk_cfg(sbc_pkg::KIND_SCALAR, 4, 0, 100, -50, 50, 0, 0);
      5:       return mk_cfg(KIND_HOLD, 4, 0, 100, -50, 50, 0, 0);
      6:       return mk_cfg(KIND_UNDEF, 4, 0, 100, -50, 50, 0, 0);
      7:       return mk_cfg(sbc_pkg::KIND_SCALAR, 0, 10, 500, 500, 500, 500, 500);
      8:       return mk_cfg(sbc_pkg::KIND_VEC3, 7, 0, 10, 20, 30, 40, 50);
      default: return mk_cfg(sbc_pkg::KIND_SCALAR, 1, 0, 0, 0, 0, 0, 0);
    endcase
  endfunction

  function automatic logic signed [sbc_pkg::COMP_W-1:0] rand_comp();
    logic signed [sbc_pkg::COMP_W-1:0] v;
    v = sbc_pkg::COMP_W'($urandom);
    case ($urandom_range(0, 9))
      0:       v = CMIN;
      1:       v = CMAX;
      2:       v = '0;
      default: v = v >>> $urandom_range(0, 15);  // spread magnitudes
    endcase
    return v;
  endfunction

  // a threshold drawn from the same distribution as the measured quantity
  function automatic longint rand_level(input logic [sbc_pkg::KIND_W-1:0] kind);
    longint s, v;
    int i, comps;
    s = 0;
    comps = (kind >= sbc_pkg::KIND_VEC2 && kind <= sbc_pkg::KIND_VEC4) ? int'(kind) + 1 : 0;
    if (comps == 0) begin
      s = rand_comp();
    end else begin
      for (i = 0; i < comps; i++) begin
        v = rand_comp();
        s += v * v;
      end
    end
    case ($urandom_range(0, 15))
      0:       s = THR_MIN;
      1:       s = THR_MAX;
      2:       s = s + 1;
      3:       s = s - 1;
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [sbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbc_pkg::THR_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);  // pipeline is two deep
  endtask

  task automatic load_cfg(input band_cfg_t c);
    int i;
    wait_results();
    write_reg(sbc_pkg::REG_VALUE_KIND, sbc_pkg::THR_W'(c.kind));
    write_reg(sbc_pkg::REG_STEP_COUNT, sbc_pkg::THR_W'(c.steps));
    for (i = 0; i < sbc_pkg::MAX_STEPS; i++)
      write_reg(sbc_pkg::CFG_IDX_W'(sbc_pkg::REG_THRESHOLD_A + i), c.thr[i]);
    @(negedge clk);
    cfg_write <= 1'b0;
    kinds_seen[c.kind] = 1'b1;
    steps_seen[c.steps] = 1'b1;
    settings_loaded++;
  endtask

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic push_sample(input logic signed [sbc_pkg::COMP_W-1:0] x, y, z, w,
                             input bit typed, input band_beat_t beat);
    @(negedge clk);
    in_valid <= 1'b1;
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    comp_w <= w;
    typed_valid <= typed;
    typed_beat <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    band_cfg_t c;
    band_beat_t nb;
    longint lv [$];
    int i, k, ph, cur_preset, r;

    dir_rows = '{
      // reset setting: one threshold at zero, stored band none
      '{4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 4'sd0},
      '{4'd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, sbc_pkg::BAND_NONE},
      '{4'd0, CMAX, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, sbc_pkg::BAND_NONE},
      '{4'd0, CMIN, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 4'sd0},
      // ascending scalar list out to the threshold extremes
      '{4'd1, CMIN, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd1, CMAX, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      // four-vector at the largest sum of squares
      '{4'd2, CMIN, CMIN, CMIN, CMIN, 1'b1, 1'b1, 4'sd5},
      '{4'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd2, CMAX, CMIN, CMIN, CMIN, 1'b0, 1'b0, 4'sd0},
      '{4'd2, CMIN, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      // descending two-vector list
      '{4'd3, CMIN, CMIN, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd3, 16'sd30, 16'sd10, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      // list that is not monotonic: band test beats the end tests
      '{4'd4, -16'sd20, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd4, -16'sd60, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd4, 16'sd75, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd4, 16'sd200, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      // never-change kind, then an undefined kind: stored band holds
      '{4'd5, -16'sd60, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0, 4'sd3},
      '{4'd5, CMAX, CMAX, CMAX, CMAX, 1'b1, 1'b0, 4'sd3},
      '{4'd6, 16'sd200, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 4'sd3},
      // step count zero acts as one, step count seven as six
      '{4'd7, 16'sd11, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd7, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'sd0},
      '{4'd8, CMIN, CMIN, CMIN, 16'sd0, 1'b0, 1'b0, 4'sd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_preset = 0;
    kinds_seen[sbc_pkg::KIND_SCALAR] = 1'b1;
    steps_seen[1] = 1'b1;
    for (i = 0; i < N_DIRECTED; i++) begin
      if (int'(dir_rows[i].preset) != cur_preset) begin
        cur_preset = dir_rows[i].preset;
        load_cfg(preset_cfg(cur_preset));
      end
      pace_sender();
      nb.chg = dir_rows[i].chg;
      nb.band = dir_rows[i].band;
      push_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w,
                  dir_rows[i].typed, nb);
    end

    nb = '0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      r = $urandom_range(0, 11);
      c.kind = (r < 8) ? sbc_pkg::KIND_W'(r % 4) : sbc_pkg::KIND_W'(r - 4);
      c.steps = sbc_pkg::STEP_W'($urandom_range(0, 7));
      lv.delete();
      for (k = 0; k < sbc_pkg::MAX_STEPS; k++) lv.push_back(rand_level(c.kind));
      case ($urandom_range(0, 7))
        0:       ;  // left unordered
        1, 2, 3: lv.sort();
        default: lv.rsort();
      endcase
      for (k = 0; k < sbc_pkg::MAX_STEPS; k++) c.thr[k] = lv[k][sbc_pkg::THR_W-1:0];
      load_cfg(c);
      for (k = 0; k < PHASE_BEATS; k++) begin
        pace_sender();
        push_sample(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1'b0, nb);
        if ($urandom_range(0, 99) == 0) wait_results();
      end
    end

    wait_results();
    repeat (4) @(posedge clk);
    if (pending_bands.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", pending_bands.size()));
    $display("Run: %0d sample beats in, %0d result beats out, %0d register settings",
             samples_in, results_out, settings_loaded);
    $display("Value kinds used %b, step counts used %b (bit n set = value n)",
             kinds_seen, steps_seen);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
